[hdl/twte_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twte_pkg: shared types and constants of the wavetable tick engine
// Holds the request and response word layouts, the operation codes, the
// register indexes and the fixed numeric constants of the datapath.
// ----------------------------------------------------------------------------
package twte_pkg;

   // operation codes carried in a request word
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_PITCH  = 2'd1,
      OP_VOLUME = 2'd2,
      OP_WRITE  = 2'd3
   } op_type;

   // register indexes of the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_SELECT = 1'd1;

   // datapath constants
   localparam int unsigned PHASE_W      = 16;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned GAIN_W       = 16;
   localparam int unsigned DAC_W        = 12;
   localparam int unsigned SETTLE_W     = 8;
   localparam int unsigned ADDR_W       = 13;
   localparam int unsigned INDEX_SHIFT  = 6;
   localparam int unsigned INDEX_W      = 10;
   localparam int unsigned GAIN_SHIFT   = 16;
   localparam int signed   DAC_MID      = 2048;
   localparam int signed   DAC_MAX      = 4095;
   localparam logic [SETTLE_W-1:0] SETTLE_LATCH = 8'd3;
   localparam logic [SETTLE_W-1:0] SETTLE_READY = 8'd5;

   // request word
   typedef struct packed {
      op_type                    op;
      logic [GAIN_W-1:0]         gain;
      logic [PHASE_W-1:0]        phase_step;
      logic [15:0]               stamp;
      logic [ADDR_W-1:0]         table_addr;
      logic signed [SAMPLE_W-1:0] table_data;
   } req_type;

   // response word
   typedef struct packed {
      logic [DAC_W-1:0] dac_code;
      logic [15:0]      pitch_period;
      logic [15:0]      volume_period;
      logic             pitch_ready;
      logic             volume_ready;
   } rsp_type;

   // settle channel result for the current tick
   typedef struct packed {
      logic [15:0] period;
      logic        ready;
   } settle_type;

   // per-tick side information that travels with the table sample
   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      settle_type        pitch;
      settle_type        volume;
   } tick_meta_type;

endpackage
`default_nettype wire

[hdl/twte_wave_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twte_wave_mem: wavetable sample store
// Single-port write, single-port read synchronous memory with a registered
// read word that holds while the read enable is low.
// ----------------------------------------------------------------------------
module twte_wave_mem #(
   parameter int unsigned DEPTH = 8192,
   parameter int unsigned AW    = 13
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [AW-1:0]                       wr_addr,
   input  wire logic signed [twte_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                                rd_en,
   input  wire logic [AW-1:0]                       rd_addr,
   output logic signed [twte_pkg::SAMPLE_W-1:0]     rd_data
);

   logic signed [twte_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [twte_pkg::SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, word held while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/twte_settle.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twte_settle: edge settle counter of one antenna channel
// Stores the latest edge stamp, counts ticks since that edge, turns the
// stamp into a period on count three and flags ready on count five.
// ----------------------------------------------------------------------------
module twte_settle (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              edge_hit,
   input  wire logic [15:0]       edge_stamp,
   input  wire logic              tick_hit,
   output twte_pkg::settle_type   result
);

   logic [15:0]                   stamp_ff, stamp_in;
   logic [15:0]                   prev_ff, prev_in;
   logic [15:0]                   interval_ff, interval_in;
   logic [twte_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic [twte_pkg::SETTLE_W-1:0] count_inc;
   logic                          latch_hit;

   // count step and the values this tick reports
   always_comb begin
      count_inc     = settle_ff + 1'b1;
      latch_hit     = (count_inc == twte_pkg::SETTLE_LATCH);
      result.period = latch_hit ? 16'(stamp_ff - prev_ff) : interval_ff;
      result.ready  = tick_hit && (count_inc == twte_pkg::SETTLE_READY);
   end

   // next state
   always_comb begin
      stamp_in    = stamp_ff;
      prev_in     = prev_ff;
      interval_in = interval_ff;
      settle_in   = settle_ff;
      priority if (edge_hit) begin
         stamp_in  = edge_stamp;
         settle_in = '0;
      end else if (tick_hit) begin
         settle_in = count_inc;
         if (latch_hit) begin
            interval_in = result.period;
            prev_in     = stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff    <= '0;
         prev_ff     <= '0;
         interval_ff <= '0;
         settle_ff   <= '0;
      end else begin
         stamp_ff    <= stamp_in;
         prev_ff     <= prev_in;
         interval_ff <= interval_in;
         settle_ff   <= settle_in;
      end
   end

endmodule
`default_nettype wire

[hdl/twte_dac_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// twte_dac_scale: gain multiply and dac code stages
// Stage one registers the signed sample times gain product, stage two
// takes the upper half, adds mid-scale, saturates and holds the response.
// ----------------------------------------------------------------------------
module twte_dac_scale (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic signed [twte_pkg::SAMPLE_W-1:0] in_sample,
   input  wire twte_pkg::tick_meta_type              in_meta,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output twte_pkg::rsp_type                         out_data
);

   localparam int unsigned PROD_W = twte_pkg::SAMPLE_W + twte_pkg::GAIN_W;
   localparam int unsigned SUM_W  = twte_pkg::SAMPLE_W + 2;

   logic                          mul_valid_ff, mul_valid_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   twte_pkg::tick_meta_type       mul_meta_ff;
   logic                          out_valid_ff, out_valid_in;
   twte_pkg::rsp_type             out_data_ff, out_data_in;
   logic                          mul_en;
   logic                          out_en;
   logic signed [PROD_W-1:0]      prod_full;
   logic signed [twte_pkg::SAMPLE_W-1:0] scaled;
   logic signed [SUM_W-1:0]       code_sum;

   // stage enables, bubbles collapse
   assign out_en   = !out_valid_ff || out_ready;
   assign mul_en   = !mul_valid_ff || out_en;
   assign in_ready = mul_en;

   // signed sample times unsigned gain, fits in 32 bits
   always_comb begin
      prod_full    = in_sample * $signed({1'b0, in_meta.gain});
      prod_in      = prod_full;
      mul_valid_in = in_valid;
   end

   // arithmetic shift by 16, offset and clamp
   always_comb begin
      scaled   = prod_ff[PROD_W-1:twte_pkg::GAIN_SHIFT];
      code_sum = SUM_W'(scaled) + SUM_W'(twte_pkg::DAC_MID);
      priority if (code_sum < 0) begin
         out_data_in.dac_code = '0;
      end else if (code_sum > SUM_W'(twte_pkg::DAC_MAX)) begin
         out_data_in.dac_code = twte_pkg::DAC_W'(twte_pkg::DAC_MAX);
      end else begin
         out_data_in.dac_code = code_sum[twte_pkg::DAC_W-1:0];
      end
      out_data_in.pitch_period  = mul_meta_ff.pitch.period;
      out_data_in.volume_period = mul_meta_ff.volume.period;
      out_data_in.pitch_ready   = mul_meta_ff.pitch.ready;
      out_data_in.volume_ready  = mul_meta_ff.volume.ready;
      out_valid_in              = mul_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_en) begin
            mul_valid_ff <= mul_valid_in;
         end
         if (out_en) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff     <= prod_in;
         mul_meta_ff <= in_meta;
      end
      if (out_en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

[hdl/theremin_wavetable_tick_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// theremin_wavetable_tick_engine: wavetable oscillator tick engine
// Phase accumulator addressing a synchronous wavetable memory, gain scaling
// to a saturated 12-bit dac code, and a pitch and a volume edge settle counter.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   request | req_valid req_ready req_data   | tick, edge or table write word
//   result  | rsp_valid rsp_ready rsp_data   | one word per enabled tick
//   csr     | csr_write csr_index csr_wdata  | enable, wave_select
//
// One request word per cycle while req_ready is high. An enabled tick's result
// word goes through the memory read register and the product register, then
// is clamped into the output register that holds it on rsp. A table write
// lands in the memory at its acceptance edge, so a tick in the next cycle
// already reads it. Reset is synchronous and needs no clearing pass;
// unwritten table entries read undefined.
// Stalls on rsp_ready fill the empty stages first, then lower req_ready.
// ----------------------------------------------------------------------------
module theremin_wavetable_tick_engine #(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned TABLE_COUNT = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire twte_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output twte_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_write,
   input  wire logic [twte_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [twte_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned STORE_SIZE = TABLE_DEPTH * TABLE_COUNT;
   localparam int unsigned MEM_AW     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

   logic                              enable_ff, enable_in;
   logic [2:0]                        wave_select_ff, wave_select_in;
   logic [twte_pkg::PHASE_W-1:0]      phase_ff, phase_in;
   logic                              rd_valid_ff, rd_valid_in;
   twte_pkg::tick_meta_type           rd_meta_ff, rd_meta_in;
   logic                              accept;
   logic                              tick_go;
   logic                              pitch_hit;
   logic                              volume_hit;
   logic                              write_go;
   logic                              rd_en;
   logic                              scale_ready;
   logic [twte_pkg::INDEX_W-1:0]      phase_index;
   int unsigned                       table_sel;
   int unsigned                       entry_sel;
   logic [MEM_AW-1:0]                 rd_addr;
   logic [MEM_AW-1:0]                 wr_addr;
   logic signed [twte_pkg::SAMPLE_W-1:0] rd_sample;
   twte_pkg::settle_type              pitch_res;
   twte_pkg::settle_type              volume_res;

   // request decode
   assign rd_en      = !rd_valid_ff || scale_ready;
   assign req_ready  = rd_en;
   assign accept     = req_valid && req_ready;
   assign tick_go    = accept && (req_data.op == twte_pkg::OP_TICK) && enable_ff;
   assign pitch_hit  = accept && (req_data.op == twte_pkg::OP_PITCH);
   assign volume_hit = accept && (req_data.op == twte_pkg::OP_VOLUME);
   assign write_go   = accept && (req_data.op == twte_pkg::OP_WRITE)
                       && (32'(req_data.table_addr) < STORE_SIZE);

   // table addressing from the phase before this tick's step
   always_comb begin
      phase_index = phase_ff[twte_pkg::INDEX_SHIFT +: twte_pkg::INDEX_W];
      table_sel   = 32'(wave_select_ff) % TABLE_COUNT;
      entry_sel   = 32'(phase_index) % TABLE_DEPTH;
      rd_addr     = MEM_AW'(table_sel * TABLE_DEPTH + entry_sel);
      wr_addr     = MEM_AW'(32'(req_data.table_addr));
   end

   // csr and phase next values
   always_comb begin
      enable_in      = enable_ff;
      wave_select_in = wave_select_ff;
      if (csr_write) begin
         unique case (csr_index)
            twte_pkg::CSR_ENABLE:      enable_in      = csr_wdata[0];
            twte_pkg::CSR_WAVE_SELECT: wave_select_in = csr_wdata[2:0];
            default: ;
         endcase
      end
      phase_in = tick_go ? 16'(phase_ff + req_data.phase_step) : phase_ff;
   end

   // side information captured alongside the memory read
   always_comb begin
      rd_valid_in       = tick_go;
      rd_meta_in.gain   = req_data.gain;
      rd_meta_in.pitch  = pitch_res;
      rd_meta_in.volume = volume_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         wave_select_ff <= '0;
         phase_ff       <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         enable_ff      <= enable_in;
         wave_select_ff <= wave_select_in;
         phase_ff       <= phase_in;
         if (rd_en) begin
            rd_valid_ff <= rd_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_meta_ff <= rd_meta_in;
      end
   end

   // wavetable store
   twte_wave_mem #(
      .DEPTH (STORE_SIZE),
      .AW    (MEM_AW)
   ) u_wave_mem (
      .clock   (clock),
      .wr_en   (write_go),
      .wr_addr (wr_addr),
      .wr_data (req_data.table_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_sample)
   );

   // pitch and volume settle counters
   twte_settle u_pitch_settle (
      .clock      (clock),
      .reset      (reset),
      .edge_hit   (pitch_hit),
      .edge_stamp (req_data.stamp),
      .tick_hit   (tick_go),
      .result     (pitch_res)
   );

   twte_settle u_volume_settle (
      .clock      (clock),
      .reset      (reset),
      .edge_hit   (volume_hit),
      .edge_stamp (req_data.stamp),
      .tick_hit   (tick_go),
      .result     (volume_res)
   );

   // gain scaling and output register
   twte_dac_scale u_dac_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_ready  (scale_ready),
      .in_sample (rd_sample),
      .in_meta   (rd_meta_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // input side only stalls when the read stage holds a tick
   a_stall_needs_tick: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rd_valid_ff)
      else $error("request stalled with empty read stage");

   // an enabled tick always enters the read stage
   a_tick_enters: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> rd_valid_ff)
      else $error("accepted tick lost before the read stage");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // ready flags only on a result word that carries them
   a_ready_on_tick: assert property (@(posedge clock) disable iff (reset)
      (pitch_res.ready || volume_res.ready) |-> tick_go)
      else $error("settle ready raised outside a tick");

endmodule
`default_nettype wire
